@@ sv/ssr_pkg.sv @@
package ssr_pkg;

    // Default sizes of the state store
    localparam int CHANNELS_DEF = 128;
    localparam int BATCH_DEF    = 16;

    // Field widths
    localparam int CH_W   = 7;
    localparam int BI_W   = 4;
    localparam int COEF_W = 16;
    localparam int X_W    = 32;

    // One input item
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic [BI_W-1:0]          batch_index;
        logic                     first_step;
        logic signed [COEF_W-1:0] a_coef;
        logic signed [COEF_W-1:0] bu_term;
        logic signed [COEF_W-1:0] c_coef;
        logic signed [COEF_W-1:0] u_value;
        logic signed [COEF_W-1:0] d_coef;
    } ssr_in_t;

    // One result item
    typedef struct packed {
        logic signed [X_W-1:0] y_out;
        logic                  saturated;
    } ssr_out_t;

    // Saturated value and its clip flag
    typedef struct packed {
        logic                  flag;
        logic signed [X_W-1:0] value;
    } ssr_sat_t;

    // Q24.24 product to Q24.16: add half an LSB, floor shift by 8
    function automatic logic signed [39:0] round_q8(input logic signed [47:0] v);
        logic signed [47:0] r;
        begin
            r = v + 48'sd128;
            round_q8 = r[47:8];
        end
    endfunction

    // Clip a 41-bit sum to the signed 32-bit range
    function automatic ssr_sat_t sat32(input logic signed [40:0] v);
        ssr_sat_t s;
        begin
            if (!v[40] && (v[39:31] != 9'h000))
            begin
                s.flag  = 1'b1;
                s.value = 32'sh7FFF_FFFF;
            end
            else if (v[40] && (v[39:31] != 9'h1FF))
            begin
                s.flag  = 1'b1;
                s.value = 32'sh8000_0000;
            end
            else
            begin
                s.flag  = 1'b0;
                s.value = v[31:0];
            end
            sat32 = s;
        end
    endfunction

endpackage

@@ sv/selective_scan_recurrence_core.sv @@
// Items are handled one at a time: the state memory read, the a*x multiply,
// the add and write-back, the x*c multiply and the final sum run in turn, and
// item_stall stays high until the result is loaded into the output register.
// Reset: control state clears at once; then a clearing pass writes zero to all
// CHANNELS*BATCH state words (2048 by default), one per cycle, while
// item_stall stays high. skip_reg resets to 0; config writes are always taken.
module selective_scan_recurrence_core #(
    parameter int CHANNELS = ssr_pkg::CHANNELS_DEF,
    parameter int BATCH    = ssr_pkg::BATCH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ssr_pkg::ssr_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output ssr_pkg::ssr_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int DEPTH = CHANNELS * BATCH;
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic                   clearing_reg;
    logic [IDX_W-1:0]       clr_idx_reg;
    logic                   skip_reg;
    logic                   accept;

    // Item held for the whole sequence
    ssr_pkg::ssr_in_t       item_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   idx_ok_reg;
    logic                   use_state_reg;

    logic [IDX_W-1:0]       idx;
    logic                   idx_ok;

    // Datapath registers
    logic signed [47:0]     prod_ax_reg;
    logic signed [31:0]     prod_ud_reg;
    logic signed [31:0]     x_reg;
    logic                   sat_x_reg;
    logic signed [47:0]     prod_xc_reg;

    logic signed [31:0]     x_cur;
    logic signed [39:0]     ax_rnd;
    logic signed [40:0]     x_sum;
    ssr_pkg::ssr_sat_t      x_sat;
    logic signed [39:0]     xc_rnd;
    logic signed [40:0]     y_sum;
    ssr_pkg::ssr_sat_t      y_sat;

    // State memory
    logic signed [31:0]     mem [DEPTH];
    logic signed [31:0]     mem_rdata_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic signed [31:0]     mem_wdata;

    // Output register
    logic                   result_valid_reg, result_valid_next;
    ssr_pkg::ssr_out_t      result_reg;
    logic                   load_result;

    assign cfg_ready    = 1'b1;
    assign item_stall   = clearing_reg || (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Entry address and range check
    assign idx_ok = (32'(item.channel) < CHANNELS) && (32'(item.batch_index) < BATCH);
    assign idx    = IDX_W'(32'(item.channel) * BATCH + 32'(item.batch_index));

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            skip_reg <= cfg_data;
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    // Memory write port: clearing pass or state write-back
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = x_sat.value;
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_ADD && idx_ok_reg)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (accept)
            mem_rdata_reg <= mem[idx];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_ADD;
            ST_ADD:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_FIN;
            ST_FIN:  if (load_result) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg      <= item;
            idx_reg       <= idx;
            idx_ok_reg    <= idx_ok;
            use_state_reg <= idx_ok && !item.first_step;
        end
    end

    // Arithmetic
    assign x_cur  = use_state_reg ? mem_rdata_reg : 32'sd0;
    assign ax_rnd = ssr_pkg::round_q8(prod_ax_reg);
    assign x_sum  = {ax_rnd[39], ax_rnd}
                  + {{17{item_reg.bu_term[15]}}, item_reg.bu_term, 8'h00};
    assign x_sat  = ssr_pkg::sat32(x_sum);
    assign xc_rnd = ssr_pkg::round_q8(prod_xc_reg);
    assign y_sum  = {xc_rnd[39], xc_rnd}
                  + (skip_reg ? {{9{prod_ud_reg[31]}}, prod_ud_reg} : 41'sd0);
    assign y_sat  = ssr_pkg::sat32(y_sum);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL1)
        begin
            prod_ax_reg <= item_reg.a_coef * x_cur;
            prod_ud_reg <= item_reg.u_value * item_reg.d_coef;
        end
        if (state_reg == ST_ADD)
        begin
            x_reg     <= x_sat.value;
            sat_x_reg <= x_sat.flag;
        end
        if (state_reg == ST_MUL2)
            prod_xc_reg <= x_reg * item_reg.c_coef;
    end

    // Output register; refills as soon as the previous result is taken
    assign load_result = (state_reg == ST_FIN) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg.y_out     <= y_sat.value;
            result_reg.saturated <= sat_x_reg | y_sat.flag;
        end
    end

    // No item is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !clearing_reg)
        else $error("item transfer during clearing pass");

    // A transfer starts the multiply sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL1)
        else $error("sequencer did not start after transfer");

    // Outside clearing, state is written only in the write-back step
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !clearing_reg) |-> (state_reg == ST_ADD && idx_ok_reg))
        else $error("stray state memory write");

    // A result appears only from the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result valid without a finished item");

endmodule

@@ tb/sv/selective_scan_recurrence_core_tb.sv @@
`timescale 1ns / 1ps

module selective_scan_recurrence_core_tb;

    localparam int CH_N       = ssr_pkg::CHANNELS_DEF;
    localparam int BT_N       = ssr_pkg::BATCH_DEF;
    localparam int DEPTH      = CH_N * BT_N;
    localparam int LONG_HOLD  = 300;
    localparam int SETTLE_CYC = 20;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    ssr_pkg::ssr_in_t  item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    ssr_pkg::ssr_out_t result;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic              cfg_data     = 1'b0;

    // Predictor state: scan memory and skip register copy
    logic signed [31:0] scan_mem [0:DEPTH-1];
    bit                 skip_model = 1'b0;
    ssr_pkg::ssr_out_t  predicted_y [$];

    int  err_count  = 0;
    bit  idle_on    = 1'b1;
    int  hold_asks  = 0;
    int  holds_done = 0;
    int  hold_left  = 0;
    logic [ssr_pkg::CH_W-1:0] hot_ch [8];
    logic [ssr_pkg::BI_W-1:0] hot_bi [8];

    selective_scan_recurrence_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            scan_mem[i] = '0;
    end

    // Clip to signed 32 bits, flag on clip
    function automatic longint clip32(input longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag   = 1'b1;
            clip32 = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            flag   = 1'b1;
            clip32 = -64'sd2147483648;
        end
        else
            clip32 = v;
    endfunction

    // One recurrence step: x = a*x + bu, y = x*c (+ u*D)
    function automatic ssr_pkg::ssr_out_t predict_scan(input ssr_pkg::ssr_in_t it);
        longint            a, bu, c, u, d, prior, x, y;
        int                entry;
        bit                in_range;
        bit                clip;
        ssr_pkg::ssr_out_t r;
        a        = it.a_coef;
        bu       = it.bu_term;
        c        = it.c_coef;
        u        = it.u_value;
        d        = it.d_coef;
        clip     = 1'b0;
        in_range = (int'(it.channel) < CH_N) && (int'(it.batch_index) < BT_N);
        entry    = in_range ? int'(it.channel) * BT_N + int'(it.batch_index) : 0;
        prior    = (in_range && !it.first_step) ? longint'(scan_mem[entry]) : 64'sd0;
        x = ((a * prior + 128) >>> 8) + bu * 256;
        x = clip32(x, clip);
        if (in_range)
            scan_mem[entry] = x[31:0];
        y = (x * c + 128) >>> 8;
        if (skip_model)
            y = y + u * d;
        y = clip32(y, clip);
        r.y_out     = y[31:0];
        r.saturated = clip;
        return r;
    endfunction

    // Scoreboard: compare results, track config, predict on each input transfer
    always @(posedge clk)
    begin : scoreboard
        ssr_pkg::ssr_out_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_y.size() == 0)
                begin
                    $error("result transfer with no expected result: y_out %0d", result.y_out);
                    err_count++;
                end
                else
                begin
                    want = predicted_y.pop_front();
                    if (result.y_out !== want.y_out)
                    begin
                        $error("y_out mismatch: expected %0d, actual %0d",
                               want.y_out, result.y_out);
                        err_count++;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, result.saturated);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                skip_model = cfg_data;
            if (item_valid && !item_stall)
                predicted_y.push_back(predict_scan(item));
        end
    end

    // Result-side stall: random bursts, plus long holds on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left = hold_left - 1;
        else if (hold_asks != holds_done)
        begin
            holds_done = hold_asks;
            hold_left  = LONG_HOLD;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
            hold_left = $urandom_range(1, 19);
        result_stall = (hold_left > 0);
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("selective_scan_recurrence_core_tb: done, errors");
        $finish;
    end

    // Drive one input transfer; called and returns at a falling edge
    task automatic send_item(input ssr_pkg::ssr_in_t it);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has arrived
    task automatic drain_results();
        item_valid = 1'b0;
        while (predicted_y.size() != 0)
            @(negedge clk);
    endtask

    // Register write; only called with the block idle
    task automatic write_skip(input bit value);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic ssr_pkg::ssr_in_t mk(input int ch, input int bi, input bit first,
                                            input logic [15:0] a, input logic [15:0] bu,
                                            input logic [15:0] c, input logic [15:0] u,
                                            input logic [15:0] d);
        ssr_pkg::ssr_in_t it;
        it.channel     = ch[ssr_pkg::CH_W-1:0];
        it.batch_index = bi[ssr_pkg::BI_W-1:0];
        it.first_step  = first;
        it.a_coef      = a;
        it.bu_term     = bu;
        it.c_coef      = c;
        it.u_value     = u;
        it.d_coef      = d;
        return it;
    endfunction

    // Coefficient mix: extremes, small values, full range
    function automatic logic [15:0] pick_coef(input bit decaying);
        case ($urandom_range(0, 9))
            0:       pick_coef = 16'h7FFF;
            1:       pick_coef = 16'h8000;
            2:       pick_coef = 16'h0000;
            3, 4, 5: pick_coef = 16'($urandom_range(0, 511) - 256);
            6:       pick_coef = decaying ? 16'($urandom_range(0, 511) - 256)
                                          : 16'($urandom_range(0, 4095) - 2048);
            default: pick_coef = 16'($urandom);
        endcase
    endfunction

    // Mostly runs on a few hot entries (back-to-back updates), some scatter
    function automatic ssr_pkg::ssr_in_t rand_item();
        ssr_pkg::ssr_in_t it;
        int               slot;
        if ($urandom_range(0, 3) != 0)
        begin
            slot           = $urandom_range(0, 7);
            it.channel     = hot_ch[slot];
            it.batch_index = hot_bi[slot];
        end
        else
        begin
            it.channel     = ssr_pkg::CH_W'($urandom);
            it.batch_index = ssr_pkg::BI_W'($urandom);
        end
        it.first_step = ($urandom_range(0, 9) == 0);
        it.a_coef     = pick_coef(1'b1);
        it.bu_term    = pick_coef(1'b0);
        it.c_coef     = pick_coef(1'b0);
        it.u_value    = pick_coef(1'b0);
        it.d_coef     = pick_coef(1'b0);
        return it;
    endfunction

    // Extremes, rounding ties, state saturation, skip term on and off
    task automatic test_directed();
        send_item(mk(0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(mk(127, 15, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        // state grows, clips low, then clips high
        send_item(mk(127, 15, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_item(mk(127, 15, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(mk(127, 15, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // negative extremes on a fresh entry, then a unit-gain continuation
        send_item(mk(64, 7, 1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(mk(64, 7, 0, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h0000));
        // rounding ties on a*x and x*c, both signs
        send_item(mk(1, 1, 1, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
        send_item(mk(1, 1, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(mk(1, 1, 0, 16'h0080, 16'h0000, 16'h0080, 16'h0000, 16'h0000));
        send_item(mk(1, 1, 0, 16'h0100, 16'h0000, 16'hFF80, 16'h0000, 16'h0000));
        send_item(mk(1, 1, 0, 16'hFF80, 16'h0000, 16'h0100, 16'h0000, 16'h0000));
        // continuation on an entry never written since reset
        send_item(mk(2, 3, 0, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000));
        // alternating bit patterns
        send_item(mk(85, 10, 1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_item(mk(42, 5, 1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        write_skip(1'b1);
        send_item(mk(0, 0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000));
        // skip term pushes the result past the top
        send_item(mk(127, 15, 1, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        // skip term pushes the result past the bottom
        send_item(mk(3, 0, 1, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_item(mk(3, 0, 0, 16'h0100, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_item(mk(5, 9, 1, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF));
        write_skip(1'b0);
    endtask

    // Receiver holds off long while the sender keeps offering back to back
    task automatic test_backpressure();
        bit saved_idle;
        drain_results();
        saved_idle = idle_on;
        idle_on    = 1'b0;
        hold_asks++;
        for (int i = 0; i < 32; i++)
            send_item(rand_item());
        drain_results();
        idle_on = saved_idle;
    endtask

    // Random phases, skip register toggled between them
    task automatic test_random_phases();
        for (int ph = 0; ph < 5; ph++)
        begin
            write_skip(ph[0] == 1'b0);
            for (int i = 0; i < 260; i++)
                send_item(rand_item());
        end
    endtask

    // Last stretch with no idling on either side
    task automatic test_quiet_tail();
        write_skip(1'b1);
        idle_on = 1'b0;
        for (int i = 0; i < 200; i++)
            send_item(rand_item());
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            hot_ch[i] = ssr_pkg::CH_W'($urandom);
            hot_bi[i] = ssr_pkg::BI_W'($urandom);
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random_phases();
        test_quiet_tail();
        drain_results();
        repeat (SETTLE_CYC) @(negedge clk);
        if (err_count == 0 && predicted_y.size() == 0)
            $display("selective_scan_recurrence_core_tb: done, clean");
        else
            $display("selective_scan_recurrence_core_tb: done, errors");
        $finish;
    end

endmodule
